>>> design/htte_pkg.sv
// Package for the markup text extractor.
// Holds the running state, input item and result types, the character constants and the depth limits.
// No dependencies.
package htte_pkg;

    // Character codes the extractor reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    // Tag depth limits.
    localparam logic signed [7:0] DEPTH_MAX = 8'sd127;
    localparam logic signed [7:0] DEPTH_MIN = -8'sd128;

    // Running extraction state.
    typedef struct packed {
        logic signed [7:0] tag_depth;
        logic              in_entity;
        logic              finished;
        logic [6:0]        emit_count;
        logic              overflowed;
    } htte_state_t;

    // One input item.
    typedef struct packed {
        logic       start_new;
        logic [7:0] cur_char;
        logic [7:0] ahead_one;
        logic [7:0] ahead_two;
        logic [7:0] ahead_three;
    } htte_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] text_char;
        logic       is_done;
        logic       was_truncated;
    } htte_result_t;

endpackage

>>> design/htte_step.sv
// Per-byte decision logic of the markup text extractor.
// Maps the current state and one item to the next state and an optional result.
// Depends on htte_pkg.
module htte_step
    import htte_pkg::*;
#(
    parameter int TEXT_CAPACITY = 100
)
(
    input  htte_state_t  state,
    input  htte_item_t   item,
    output htte_state_t  state_next,
    output logic         res_valid,
    output htte_result_t res
);

    localparam logic [6:0] STORE_LIMIT = 7'(TEXT_CAPACITY - 1);

    // Paragraph, line break or closing tag that ends the extraction.
    logic stop_tag;
    always_comb
    begin
        stop_tag = (item.ahead_one == CH_P)
            || (item.ahead_one == CH_B && item.ahead_two == CH_R)
            || (item.ahead_one == CH_SLASH && item.ahead_two == CH_H
                && item.ahead_three == CH_ONE)
            || (item.ahead_one == CH_SLASH && item.ahead_two == CH_T
                && (item.ahead_three == CH_H || item.ahead_three == CH_D));
    end

    // Decision for one byte.
    always_comb
    begin
        htte_state_t st;
        st = state;
        if (item.start_new)
        begin
            st = '0;
        end
        res_valid = 1'b0;
        res       = '0;
        state_next = st;
        if (!st.finished)
        begin
            if (item.cur_char == CH_NUL)
            begin
                state_next.finished = 1'b1;
                res_valid           = 1'b1;
                res.is_done         = 1'b1;
                res.was_truncated   = st.overflowed;
            end
            else if (st.in_entity)
            begin
                // Skip everything up to the closing semicolon.
                if (item.cur_char == CH_SEMI)
                begin
                    state_next.in_entity = 1'b0;
                end
            end
            else if (item.cur_char == CH_LT)
            begin
                if (stop_tag)
                begin
                    state_next.finished = 1'b1;
                    res_valid           = 1'b1;
                    res.is_done         = 1'b1;
                    res.was_truncated   = st.overflowed;
                end
                else if (st.tag_depth != DEPTH_MAX)
                begin
                    state_next.tag_depth = st.tag_depth + 8'sd1;
                end
            end
            else if (item.cur_char == CH_GT)
            begin
                if (st.tag_depth != DEPTH_MIN)
                begin
                    state_next.tag_depth = st.tag_depth - 8'sd1;
                end
            end
            else if (st.tag_depth != 8'sd0 || item.cur_char == CH_QUOTE)
            begin
                // Inside a tag, or a quote: nothing to do.
            end
            else if (item.cur_char == CH_AMP)
            begin
                state_next.in_entity = 1'b1;
            end
            else if (item.cur_char == CH_CR || item.cur_char == CH_LF)
            begin
                // Line breaks are not text.
            end
            else if (st.emit_count >= STORE_LIMIT)
            begin
                state_next.overflowed = 1'b1;
            end
            else
            begin
                state_next.emit_count = st.emit_count + 7'd1;
                // A space as the first stored character is counted but not sent.
                if (!(st.emit_count == 7'd0 && item.cur_char == CH_SPACE))
                begin
                    res_valid     = 1'b1;
                    res.text_char = item.cur_char;
                end
            end
        end
    end

endmodule

>>> design/htte_outq.sv
// Two-entry result queue of the markup text extractor.
// Decouples the decision stage from a stalled output channel. Depends on htte_pkg.
module htte_outq
    import htte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  htte_result_t push_data,
    output logic         room,
    output logic         out_valid,
    input  logic         out_stall,
    output htte_result_t out_data
);

    htte_result_t mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         pop;

    // Handshake on the output side.
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg != 2'd2) || pop;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("result pushed into a full queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_ptrs_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

>>> design/html_tag_text_extractor_unit.sv
// Top level of the markup text extractor. Depends on htte_pkg, htte_step, htte_outq.
// Also holds the input register and the running extraction state.
//
// One markup byte, with three bytes of lookahead, is taken per beat, and a new
// beat can be accepted every cycle. A beat is registered, decided against the
// running state, and its result (a text byte or a done marker, or nothing)
// enters a two-entry queue; a result passes the input register and then the queue
// before it is offered on the output. The throughput of one beat per cycle is set
// by the single decision stage; the input stalls only while the output channel
// stalls and the queue is full. Beats after a done marker are ignored until one
// arrives with start_new set.
module html_tag_text_extractor_unit
    import htte_pkg::*;
#(
    parameter int TEXT_CAPACITY = 100
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       start_new,
    input  logic [7:0] cur_char,
    input  logic [7:0] ahead_one,
    input  logic [7:0] ahead_two,
    input  logic [7:0] ahead_three,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] text_char,
    output logic       is_done,
    output logic       was_truncated
);

    logic         stage_valid_reg;
    htte_item_t   stage_item_reg;
    htte_state_t  state_reg;
    htte_state_t  state_next;
    logic         res_valid;
    htte_result_t res;
    logic         room;
    logic         stage_move;
    logic         in_take;
    htte_result_t out_data;

    // Decision logic for the registered beat.
    htte_step #(
        .TEXT_CAPACITY (TEXT_CAPACITY)
    ) u_step (
        .state      (state_reg),
        .item       (stage_item_reg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    // The stage empties when its result, if any, fits in the queue.
    assign stage_move = stage_valid_reg && (!res_valid || room);
    assign in_stall   = stage_valid_reg && !stage_move;
    assign in_take    = in_valid && !in_stall;

    // Input register and stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (stage_move)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_item_reg <= '{start_new, cur_char, ahead_one, ahead_two, ahead_three};
        end
    end

    // Running extraction state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{tag_depth: 8'sd0, in_entity: 1'b0, finished: 1'b1,
                           emit_count: 7'd0, overflowed: 1'b0};
        end
        else if (stage_move)
        begin
            state_reg <= state_next;
        end
    end

    // Result queue towards the output channel.
    htte_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_move && res_valid),
        .push_data (res),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign text_char     = out_data.text_char;
    assign is_done       = out_data.is_done;
    assign was_truncated = out_data.was_truncated;

`ifndef ASSERT_OFF
    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (stage_valid_reg && res_valid && !room))
        else $error("input stalled without a blocked result");
    a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_move && res_valid && res.is_done) |=> state_reg.finished)
        else $error("done result without finishing");
    a_idle_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && state_reg.finished && !stage_item_reg.start_new)
        |-> (!res_valid && state_next == state_reg))
        else $error("activity while idle");
    a_text_at_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.is_done && !stage_item_reg.start_new)
        |-> (state_reg.tag_depth == 8'sd0 && !state_reg.in_entity))
        else $error("text emitted inside a tag or entity");
`endif

endmodule

>>> verif/htte_text_checker.sv
// Checker for the markup text extractor: watches both channels, predicts each result
// from the accepted input beats and compares it with what the block returns.
// Depends on htte_pkg for the state, beat and result types and the character codes.
module htte_text_checker
    import htte_pkg::*;
#(
    parameter int TEXT_CAPACITY = 100
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       start_new,
    input  logic [7:0] cur_char,
    input  logic [7:0] ahead_one,
    input  logic [7:0] ahead_two,
    input  logic [7:0] ahead_three,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] text_char,
    input  logic       is_done,
    input  logic       was_truncated,
    output int         fail_count,
    output int         pending_results
);

    // Predicted extraction state and the results still owed by the block.
    htte_state_t  extract_state;
    htte_result_t awaited_text[$];
    htte_item_t   seen_beat;
    htte_result_t seen_result;
    htte_result_t oldest_result;
    htte_result_t next_result;

    // Advances the predicted state by one beat; returns 1 when the beat yields a result.
    function automatic bit extract_beat(input htte_item_t beat, output htte_result_t res);
        logic [7:0] ch;
        bit         stop_tag;
        ch = beat.cur_char;
        res = '0;
        if (beat.start_new)
            extract_state = '0;
        if (extract_state.finished)
            return 1'b0;
        stop_tag = (beat.ahead_one == CH_P)
            || (beat.ahead_one == CH_B && beat.ahead_two == CH_R)
            || (beat.ahead_one == CH_SLASH && beat.ahead_two == CH_H
                && beat.ahead_three == CH_ONE)
            || (beat.ahead_one == CH_SLASH && beat.ahead_two == CH_T
                && (beat.ahead_three == CH_H || beat.ahead_three == CH_D));
        // The end of the string, or a stop tag at any depth, closes the extraction.
        if (ch == CH_NUL || (!extract_state.in_entity && ch == CH_LT && stop_tag))
        begin
            extract_state.finished = 1'b1;
            res.is_done = 1'b1;
            res.was_truncated = extract_state.overflowed;
            return 1'b1;
        end
        // Inside an entity everything up to the semicolon is skipped.
        if (extract_state.in_entity)
        begin
            if (ch == CH_SEMI)
                extract_state.in_entity = 1'b0;
            return 1'b0;
        end
        // Tag depth moves and saturates at both ends.
        if (ch == CH_LT)
        begin
            if (extract_state.tag_depth != DEPTH_MAX)
                extract_state.tag_depth = extract_state.tag_depth + 8'sd1;
            return 1'b0;
        end
        if (ch == CH_GT)
        begin
            if (extract_state.tag_depth != DEPTH_MIN)
                extract_state.tag_depth = extract_state.tag_depth - 8'sd1;
            return 1'b0;
        end
        if (extract_state.tag_depth != 8'sd0 || ch == CH_QUOTE)
            return 1'b0;
        if (ch == CH_AMP)
        begin
            extract_state.in_entity = 1'b1;
            return 1'b0;
        end
        if (ch == CH_CR || ch == CH_LF)
            return 1'b0;
        // Beyond capacity the byte is dropped and the loss remembered.
        if (int'(extract_state.emit_count) >= TEXT_CAPACITY - 1)
        begin
            extract_state.overflowed = 1'b1;
            return 1'b0;
        end
        extract_state.emit_count = extract_state.emit_count + 7'd1;
        if (extract_state.emit_count == 7'd1 && ch == CH_SPACE)
            return 1'b0;
        res.text_char = ch;
        return 1'b1;
    endfunction

    // Predict on every accepted input beat and compare every accepted output beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extract_state = '0;
            extract_state.finished = 1'b1;
            awaited_text.delete();
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                seen_beat.start_new   = start_new;
                seen_beat.cur_char    = cur_char;
                seen_beat.ahead_one   = ahead_one;
                seen_beat.ahead_two   = ahead_two;
                seen_beat.ahead_three = ahead_three;
                if (extract_beat(seen_beat, next_result))
                    awaited_text.push_back(next_result);
            end
            if (out_valid && !out_stall)
            begin
                seen_result.text_char     = text_char;
                seen_result.is_done       = is_done;
                seen_result.was_truncated = was_truncated;
                if (awaited_text.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: text_char=%02h is_done=%0b was_truncated=%0b",
                                 text_char, is_done, was_truncated);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    oldest_result = awaited_text.pop_front();
                    if (seen_result.text_char !== oldest_result.text_char
                        || seen_result.is_done !== oldest_result.is_done
                        || seen_result.was_truncated !== oldest_result.was_truncated)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected text_char=%02h is_done=%0b ",
                                     oldest_result.text_char, oldest_result.is_done,
                                     "was_truncated=%0b, got text_char=%02h ",
                                     oldest_result.was_truncated, text_char,
                                     "is_done=%0b was_truncated=%0b",
                                     is_done, was_truncated);
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending_results = awaited_text.size();
        end
    end

endmodule

>>> verif/tb_html_tag_text_extractor_unit.sv
// Testbench top for the markup text extractor: drives markup strings with lookahead,
// random idling on both channels, and gives the verdict.
// Depends on htte_pkg, html_tag_text_extractor_unit and htte_text_checker.
module tb_html_tag_text_extractor_unit;
    import htte_pkg::*;

    localparam int TEXT_CAPACITY  = 100;
    localparam int RANDOM_ITEMS   = 1350;
    localparam int WATCHDOG_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       start_new = 1'b0;
    logic [7:0] cur_char = 8'h00;
    logic [7:0] ahead_one = 8'h00;
    logic [7:0] ahead_two = 8'h00;
    logic [7:0] ahead_three = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] text_char;
    logic       is_done;
    logic       was_truncated;

    int         fail_count;
    int         pending_results;
    int         idle_cycles = 0;
    int         items_sent = 0;
    int         seq_idx = 0;
    bit         calm = 1'b0;
    logic [7:0] markup[$];

    html_tag_text_extractor_unit #(.TEXT_CAPACITY(TEXT_CAPACITY)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_new(start_new), .cur_char(cur_char),
        .ahead_one(ahead_one), .ahead_two(ahead_two), .ahead_three(ahead_three),
        .out_valid(out_valid), .out_stall(out_stall),
        .text_char(text_char), .is_done(is_done), .was_truncated(was_truncated)
    );

    htte_text_checker #(.TEXT_CAPACITY(TEXT_CAPACITY)) result_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_new(start_new), .cur_char(cur_char),
        .ahead_one(ahead_one), .ahead_two(ahead_two), .ahead_three(ahead_three),
        .out_valid(out_valid), .out_stall(out_stall),
        .text_char(text_char), .is_done(is_done), .was_truncated(was_truncated),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    always #4 clk = ~clk;

    // The receiver stalls at random, except during the calm stretch.
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 11);

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL html_tag_text_extractor_unit");
                $finish;
            end
        end
    end

    // Offers one beat, with random idle cycles before it, and returns once it is taken.
    task automatic send_beat(input bit sn, input logic [7:0] ch, input logic [7:0] a1,
                             input logic [7:0] a2, input logic [7:0] a3);
        bit stalled;
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_new   <= sn;
        cur_char    <= ch;
        ahead_one   <= a1;
        ahead_two   <= a2;
        ahead_three <= a3;
        // The stall is read at the falling edge before the edge that would take the beat.
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        while (stalled);
    endtask

    // Sends the composed markup with its lookahead; noisy sequences corrupt it at times.
    task automatic send_markup(input bit noisy);
        logic [7:0] look[3];
        for (int i = 0; i < markup.size(); i++)
        begin
            for (int k = 0; k < 3; k++)
                look[k] = (i + k + 1 < markup.size()) ? markup[i + k + 1] : CH_NUL;
            if (noisy && $urandom_range(0, 3) == 0)
                look[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
            send_beat(i == 0 || (noisy && $urandom_range(0, 24) == 0), markup[i],
                      look[0], look[1], look[2]);
        end
        items_sent += markup.size();
        markup.delete();
    endtask

    task automatic push_text(input string s);
        foreach (s[j])
            markup.push_back(s[j]);
    endtask

    task automatic push_stop_tag();
        case ($urandom_range(0, 4))
            0: push_text("<p");
            1: push_text("<br");
            2: push_text("</h1");
            3: push_text("</th");
            default: push_text("</td");
        endcase
    endtask

    // Lowers valid and holds off until every predicted result has been returned.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int pieces;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Leading space, the highest byte, quote, CR, LF and an entity.
        push_text(" ");
        markup.push_back(8'hFF);
        push_text("x\"");
        markup.push_back(CH_CR);
        markup.push_back(CH_LF);
        push_text("&lt;y");
        markup.push_back(CH_NUL);
        send_markup(1'b0);
        // An entity with no semicolon swallows tags until the end of the string.
        push_text("&<>");
        markup.push_back(CH_NUL);
        send_markup(1'b0);
        // Near misses of stop tags raise the depth; a real one ends the extraction.
        push_text("</h2>b</th");
        send_markup(1'b0);
        push_text("<p");
        send_markup(1'b0);
        drain_results();

        // Random part: mostly well-formed markup, some noise, long and deeply nested runs.
        while (items_sent < RANDOM_ITEMS)
        begin
            calm = (seq_idx >= 8 && seq_idx < 16);
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                pieces = $urandom_range(1, 12);
                repeat (pieces)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2:
                        begin
                            repeat ($urandom_range(1, 8))
                                markup.push_back($urandom_range(0, 3) == 0
                                    ? 8'($urandom_range(8'h20, 8'h7E))
                                    : 8'($urandom_range(8'h61, 8'h7A)));
                        end
                        3: markup.push_back(CH_SPACE);
                        4:
                        begin
                            markup.push_back(CH_LT);
                            repeat ($urandom_range(1, 4))
                                markup.push_back(8'($urandom_range(8'h63, 8'h6F)));
                            if ($urandom_range(0, 2) == 0)
                                push_text(" a=\"v\"");
                            markup.push_back(CH_GT);
                        end
                        5:
                        begin
                            push_text("</");
                            repeat ($urandom_range(1, 4))
                                markup.push_back(8'($urandom_range(8'h63, 8'h6F)));
                            markup.push_back(CH_GT);
                        end
                        6:
                        begin
                            markup.push_back(CH_AMP);
                            repeat ($urandom_range(2, 5))
                                markup.push_back(8'($urandom_range(8'h61, 8'h7A)));
                            if ($urandom_range(0, 4) != 0)
                                markup.push_back(CH_SEMI);
                        end
                        7:
                        begin
                            case ($urandom_range(0, 2))
                                0: markup.push_back(CH_QUOTE);
                                1: markup.push_back(CH_CR);
                                default: markup.push_back(CH_LF);
                            endcase
                        end
                        8: markup.push_back(CH_GT);
                        default: push_text("<b>x</b>");
                    endcase
                end
                // Close with the end of the string, a stop tag, or not at all.
                kind = $urandom_range(0, 9);
                if (kind < 6)
                    markup.push_back(CH_NUL);
                else if (kind < 9)
                begin
                    push_stop_tag();
                    if ($urandom_range(0, 1) == 0)
                        push_text("tail");
                    markup.push_back(CH_NUL);
                end
                send_markup(1'b0);
            end
            else if (kind < 85)
            begin
                repeat ($urandom_range(5, 30))
                    markup.push_back(8'($urandom_range(1, 255)));
                markup.push_back(8'($urandom_range(0, 3)));
                send_markup(1'b1);
            end
            else if (kind < 93)
            begin
                // Text around the capacity, mostly enough to run past it.
                repeat ($urandom_range(TEXT_CAPACITY - 5, TEXT_CAPACITY + 30))
                    markup.push_back(8'($urandom_range(8'h61, 8'h7A)));
                markup.push_back(CH_NUL);
                send_markup(1'b0);
            end
            else if (kind < 97)
            begin
                // Depth held at its upper limit must come back to zero after 127 closes.
                repeat ($urandom_range(128, 135))
                    markup.push_back(CH_LT);
                push_text("ab");
                repeat (127)
                    markup.push_back(CH_GT);
                push_text("cd");
                markup.push_back(CH_NUL);
                send_markup(1'b0);
            end
            else
            begin
                // Depth held at its lower limit must come back to zero after 128 opens.
                repeat ($urandom_range(129, 135))
                    markup.push_back(CH_GT);
                repeat (128)
                    markup.push_back(CH_LT);
                push_text("ok");
                markup.push_back(CH_NUL);
                send_markup(1'b0);
            end
            // Stray beats after the end are normally ignored by the block.
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3))
                    send_beat(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            if (seq_idx % 7 == 6)
                drain_results();
            seq_idx++;
        end

        // Let the last results out, then allow the pipeline to settle.
        calm = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS html_tag_text_extractor_unit");
        else
            $display("FAIL html_tag_text_extractor_unit");
        $finish;
    end

endmodule
